// ----- design/wsci_pkg.sv -----
// Package for the windowed sample channel interleaver.
// Holds field widths, fixed-point constants, the slot tag struct and Taylor divisors.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package wsci_pkg;

    // Field widths
    localparam int ADC_W    = 12;
    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 4;
    localparam int CHAN_W   = 3;
    localparam int SLOT_W   = 8;

    // Magnitude of (code - midscale) needs one bit more than the offset code half
    localparam int MAG_W    = 12;

    // Defaults for the top-level parameters
    localparam int DEFAULT_FRAME_LEN = 256;
    localparam int DEFAULT_COEF_BITS = 16;

    // Sample constants
    localparam logic [ADC_W-1:0]    MIDSCALE       = 12'd2048;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 12'sd2047;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN     = 12'h800;
    localparam int                  SAMPLE_MIN_MAG = 2048;
    localparam int                  SAMPLE_MAX_MAG = 2047;

    // Gain register reset value
    localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd5;

    // Last channel slot before the frame position advances
    localparam logic [CHAN_W-1:0] LAST_CHANNEL = 3'd7;

    // Q2.30 constants for building the window table at elaboration
    localparam longint          Q30_ONE      = 64'sd1073741824;
    localparam longint unsigned PI_Q30       = 64'd3373259426;
    localparam longint unsigned COEF_HALF    = 64'd53687091200;   // 50 * 2^30
    localparam longint unsigned COEF_DEN     = 64'd107374182400;  // 100 * 2^30
    localparam int              TAYLOR_TERMS = 12;

    // Taylor step divisors (2k-1)*2k for k = 1..12
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    // Slot bookkeeping carried along with each sample
    typedef struct packed {
        logic [CHAN_W-1:0] channel_slot;
        logic [SLOT_W-1:0] frame_slot;
        logic              bank_sel;
        logic              frame_done;
        logic [CHAN_W-1:0] next_channel;
    } slot_tag_t;

endpackage

`default_nettype wire

// ----- design/wsci_if.sv -----
// Channel interfaces for the windowed sample channel interleaver.
// ADC input, result output and gain configuration channels; depends on wsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

// ADC code channel
interface wsci_adc_if;
    logic                        valid;
    logic                        ready;
    logic [wsci_pkg::ADC_W-1:0]  adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

// Result channel
interface wsci_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [wsci_pkg::SAMPLE_W-1:0] sample_out;
    logic [wsci_pkg::CHAN_W-1:0]        channel_slot;
    logic [wsci_pkg::SLOT_W-1:0]        frame_slot;
    logic                               bank_sel;
    logic                               frame_done;
    logic [wsci_pkg::CHAN_W-1:0]        next_channel;

    modport source (output valid, output sample_out, output channel_slot,
                    output frame_slot, output bank_sel, output frame_done,
                    output next_channel, input ready);
    modport sink   (input valid, input sample_out, input channel_slot,
                    input frame_slot, input bank_sel, input frame_done,
                    input next_channel, output ready);
endinterface

// Gain write channel
interface wsci_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [wsci_pkg::GAIN_W-1:0] adc_gain;

    modport source (output valid, output adc_gain, input ready);
    modport sink   (input valid, input adc_gain, output ready);
endinterface

`default_nettype wire

// ----- design/wsci_window_rom.sv -----
// Hamming window coefficient table with a registered read port.
// Coefficients are built at elaboration from the fixed-point cosine series; uses wsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsci_window_rom #(
    parameter int FRAME_LEN = wsci_pkg::DEFAULT_FRAME_LEN,
    parameter int COEF_BITS = wsci_pkg::DEFAULT_COEF_BITS,
    parameter int POS_W     = $clog2(FRAME_LEN)
) (
    input  wire logic                 clk,
    input  wire logic [POS_W-1:0]     addr,
    output logic      [COEF_BITS-1:0] coef_reg
);

    localparam longint unsigned FRAME_MAX = longint'(FRAME_LEN - 1);
    localparam int              COEF_FRAC = COEF_BITS - 1;

    // cos(2*pi*idx/(N-1)) in Q2.30, angle folded into the first quadrant,
    // then 0.54 - 0.46*cos rounded half up to Q1.F
    function automatic logic [COEF_BITS-1:0] hamming_coef(input int unsigned idx);
        longint unsigned j;
        longint unsigned m;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned w;
        longint          sum;
        longint          c;
        longint          num;
        logic            neg;
        j   = longint'(idx);
        neg = 1'b0;
        if (j > FRAME_MAX)
            j = FRAME_MAX;
        if (2 * j > FRAME_MAX)
            j = FRAME_MAX - j;
        if (4 * j > FRAME_MAX)
        begin
            m   = FRAME_MAX - 2 * j;
            neg = 1'b1;
        end
        else
        begin
            m = 2 * j;
        end
        a    = (m * wsci_pkg::PI_Q30) / FRAME_MAX;
        a2   = (a * a) >> 30;
        sum  = wsci_pkg::Q30_ONE;
        term = longint'(wsci_pkg::Q30_ONE);
        for (int k = 0; k < wsci_pkg::TAYLOR_TERMS; k++)
        begin
            term = ((term * a2) >> 30) / wsci_pkg::TAYLOR_DIV[k];
            if ((k % 2) == 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        c   = neg ? -sum : sum;
        num = 54 * wsci_pkg::Q30_ONE - 46 * c;
        if (num < 0)
            num = 0;
        w = ((longint'(num) << COEF_FRAC) + wsci_pkg::COEF_HALF) / wsci_pkg::COEF_DEN;
        return w[COEF_BITS-1:0];
    endfunction

    logic [COEF_BITS-1:0] rom_tbl [FRAME_LEN];

    // Constant table, one entry per frame position
    for (genvar g = 0; g < FRAME_LEN; g++)
    begin : g_rom
        localparam logic [COEF_BITS-1:0] COEF = hamming_coef(g);
        assign rom_tbl[g] = COEF;
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        coef_reg <= rom_tbl[addr];
    end

endmodule

`default_nettype wire

// ----- design/wsci_slot_ctrl.sv -----
// Channel, frame position and ping-pong bank counters.
// Produces the slot tag for the current item and the window table address; uses wsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsci_slot_ctrl #(
    parameter int FRAME_LEN = wsci_pkg::DEFAULT_FRAME_LEN,
    parameter int POS_W     = $clog2(FRAME_LEN)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    output logic [POS_W-1:0]         pos,
    output wsci_pkg::slot_tag_t      tag
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [wsci_pkg::CHAN_W-1:0] chan_reg;
    logic [wsci_pkg::CHAN_W-1:0] chan_next;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic                        bank_reg;
    logic                        bank_next;
    logic                        last_chan;
    logic                        wrap;

    assign last_chan = (chan_reg == wsci_pkg::LAST_CHANNEL);
    assign wrap      = last_chan && (pos_reg == LAST_POS);

    // Next counter values for one item
    always_comb
    begin
        chan_next = chan_reg + 1'b1;
        pos_next  = pos_reg;
        bank_next = bank_reg;
        if (last_chan)
        begin
            pos_next = wrap ? '0 : pos_reg + 1'b1;
            if (wrap)
                bank_next = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            pos_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else if (advance)
        begin
            chan_reg <= chan_next;
            pos_reg  <= pos_next;
            bank_reg <= bank_next;
        end
    end

    // Tag seen by the item accepted this cycle
    assign pos                = pos_reg;
    assign tag.channel_slot   = chan_reg;
    assign tag.frame_slot     = wsci_pkg::SLOT_W'(pos_reg);
    assign tag.bank_sel       = bank_reg;
    assign tag.frame_done     = wrap;
    assign tag.next_channel   = chan_next;

endmodule

`default_nettype wire

// ----- design/wsci_seq.sv -----
// Sequencer around one shared multiplier: offset removal, window, gain, saturation.
// Takes the coefficient from wsci_window_rom and the slot tag from wsci_slot_ctrl; uses wsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsci_seq #(
    parameter int COEF_BITS = wsci_pkg::DEFAULT_COEF_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [wsci_pkg::ADC_W-1:0]        adc_code,
    input  wire wsci_pkg::slot_tag_t               tag_in,
    input  wire logic [wsci_pkg::GAIN_W-1:0]       gain,
    input  wire logic [COEF_BITS-1:0]              coef,
    input  wire logic                              out_free,
    output logic                                   idle,
    output logic                                   load,
    output logic [wsci_pkg::SAMPLE_W-1:0]          sample,
    output wsci_pkg::slot_tag_t                    tag_out
);

    localparam int COEF_FRAC = COEF_BITS - 1;
    localparam int A_W       = wsci_pkg::MAG_W + COEF_BITS;
    localparam int B_W       = COEF_BITS;
    localparam int PROD_W    = A_W + wsci_pkg::GAIN_W;
    localparam int SHIFT_W   = PROD_W - COEF_FRAC;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WIN  = 2'd1;
    localparam logic [1:0] S_GAIN = 2'd2;
    localparam logic [1:0] S_SAT  = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [wsci_pkg::MAG_W-1:0]  mag_reg;
    logic                        neg_reg;
    logic [PROD_W-1:0]           prod_reg;
    wsci_pkg::slot_tag_t         tag_reg;

    logic [A_W-1:0]              mul_a;
    logic [B_W-1:0]              mul_b;
    logic [A_W+B_W-1:0]          mul_p;
    logic [SHIFT_W-1:0]          shifted;
    logic [wsci_pkg::MAG_W-1:0]  mag_in;

    // Magnitude of code minus midscale
    assign mag_in = adc_code[wsci_pkg::ADC_W-1]
                  ? (adc_code - wsci_pkg::MIDSCALE)
                  : (wsci_pkg::MIDSCALE - adc_code);

    // Shared multiplier: magnitude x coefficient, then product x gain
    always_comb
    begin
        if (state_reg == S_WIN)
        begin
            mul_a = A_W'(mag_reg);
            mul_b = coef;
        end
        else
        begin
            mul_a = prod_reg[A_W-1:0];
            mul_b = B_W'(gain);
        end
    end
    assign mul_p = mul_a * mul_b;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_WIN;
            S_WIN:  state_next = S_GAIN;
            S_GAIN: state_next = S_SAT;
            S_SAT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Operand and product registers
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            mag_reg <= mag_in;
            neg_reg <= ~adc_code[wsci_pkg::ADC_W-1];
            tag_reg <= tag_in;
        end
        if ((state_reg == S_WIN) || (state_reg == S_GAIN))
            prod_reg <= PROD_W'(mul_p);
    end

    // Drop fraction bits and clamp to the signed sample range
    assign shifted = prod_reg[PROD_W-1:COEF_FRAC];

    always_comb
    begin
        if (neg_reg)
        begin
            if (shifted > SHIFT_W'(wsci_pkg::SAMPLE_MIN_MAG))
                sample = wsci_pkg::SAMPLE_MIN;
            else
                sample = {wsci_pkg::SAMPLE_W{1'b0}} - shifted[wsci_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            if (shifted > SHIFT_W'(wsci_pkg::SAMPLE_MAX_MAG))
                sample = wsci_pkg::SAMPLE_MAX;
            else
                sample = shifted[wsci_pkg::SAMPLE_W-1:0];
        end
    end

    assign idle    = (state_reg == S_IDLE);
    assign load    = (state_reg == S_SAT) && out_free;
    assign tag_out = tag_reg;

endmodule

`default_nettype wire

// ----- design/windowed_sample_channel_interleaver_core.sv -----
// Top level of the windowed sample channel interleaver.
// Instantiates wsci_slot_ctrl, wsci_window_rom and wsci_seq; uses wsci_pkg and the wsci_if channels.
`timescale 1ns / 1ps
`default_nettype none

// Each ADC code beat is offset to signed, multiplied by a Hamming window
// coefficient chosen by the frame position and then by the 4-bit gain, truncated
// toward zero and clamped to 12-bit signed. Channel slots rotate 0..7; after slot
// 7 the frame position advances, and on wrap the write bank flips and frame_done
// is set on that one result. The accept cycle latches the table read, then the
// single shared multiplier runs twice (window, then gain) and a final state
// clamps and loads the result register, holding while the output register is
// full. adc.ready is high only while that multiplier sequence is idle; a
// finished result may wait in the output register while the next beat is taken.
// The gain register may be written at any cycle when no beat is in flight.

module windowed_sample_channel_interleaver_core #(
    parameter int FRAME_LEN = wsci_pkg::DEFAULT_FRAME_LEN,
    parameter int COEF_BITS = wsci_pkg::DEFAULT_COEF_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wsci_adc_if.sink    adc,
    wsci_result_if.source result,
    wsci_cfg_if.sink    cfg
);

    localparam int POS_W = $clog2(FRAME_LEN);

    logic [wsci_pkg::GAIN_W-1:0]   gain_reg;
    logic [POS_W-1:0]              pos;
    logic [COEF_BITS-1:0]          coef;
    wsci_pkg::slot_tag_t           tag_cur;
    wsci_pkg::slot_tag_t           tag_done;
    logic                          seq_idle;
    logic                          seq_load;
    logic [wsci_pkg::SAMPLE_W-1:0] seq_sample;
    logic                          adc_accept;
    logic                          out_free;

    logic                          out_valid_reg;
    logic [wsci_pkg::SAMPLE_W-1:0] sample_reg;
    wsci_pkg::slot_tag_t           tag_reg;

    // Gain register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= wsci_pkg::GAIN_RESET;
        else if (cfg.valid)
            gain_reg <= cfg.adc_gain;
    end

    // Input handshake
    assign adc.ready  = seq_idle;
    assign adc_accept = adc.valid && seq_idle;

    wsci_slot_ctrl #(
        .FRAME_LEN (FRAME_LEN),
        .POS_W     (POS_W)
    ) u_slot (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (adc_accept),
        .pos     (pos),
        .tag     (tag_cur)
    );

    wsci_window_rom #(
        .FRAME_LEN (FRAME_LEN),
        .COEF_BITS (COEF_BITS),
        .POS_W     (POS_W)
    ) u_rom (
        .clk      (clk),
        .addr     (pos),
        .coef_reg (coef)
    );

    wsci_seq #(
        .COEF_BITS (COEF_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (adc_accept),
        .adc_code (adc.adc_code),
        .tag_in   (tag_cur),
        .gain     (gain_reg),
        .coef     (coef),
        .out_free (out_free),
        .idle     (seq_idle),
        .load     (seq_load),
        .sample   (seq_sample),
        .tag_out  (tag_done)
    );

    // Output register
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= seq_load;
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            sample_reg <= seq_sample;
            tag_reg    <= tag_done;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.sample_out   = sample_reg;
    assign result.channel_slot = tag_reg.channel_slot;
    assign result.frame_slot   = tag_reg.frame_slot;
    assign result.bank_sel     = tag_reg.bank_sel;
    assign result.frame_done   = tag_reg.frame_done;
    assign result.next_channel = tag_reg.next_channel;

endmodule

`default_nettype wire

// ----- design/wsci_checker.sv -----
// Port-level checker for the windowed sample channel interleaver, and its bind.
// Watches only the top-level channels; depends on wsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsci_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [wsci_pkg::SAMPLE_W-1:0]     sample_out,
    input wire logic [wsci_pkg::CHAN_W-1:0]       channel_slot,
    input wire logic                              frame_done,
    input wire logic [wsci_pkg::CHAN_W-1:0]       next_channel
);

    // While a beat is in the sequencer, no new beat is taken right behind it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("input accepted again while previous beat in flight");

    // Slot rotation seen on the result
    a_next_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (next_channel == wsci_pkg::CHAN_W'(channel_slot + 1'b1)))
        else $error("next_channel does not follow channel_slot");

    // Frame completion only on the last channel slot
    a_frame_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (channel_slot == wsci_pkg::LAST_CHANNEL))
        else $error("frame_done outside last channel slot");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
        else $error("stalled result dropped or changed");

endmodule

bind windowed_sample_channel_interleaver_core wsci_checker u_wsci_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (adc.valid),
    .in_ready     (adc.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .sample_out   (result.sample_out),
    .channel_slot (result.channel_slot),
    .frame_done   (result.frame_done),
    .next_channel (result.next_channel)
);

`default_nettype wire

// ----- tb/windowed_sample_channel_interleaver_core_tb.sv -----
// Testbench for windowed_sample_channel_interleaver_core: randomized ADC beats with
// random stalls on both sides, checked against an in-bench window/gain/slot predictor.
// Depends on wsci_pkg, the wsci_if channel interfaces and the core RTL.
`timescale 1ns / 1ps

module windowed_sample_channel_interleaver_core_tb;

    localparam int FRAME_LEN  = wsci_pkg::DEFAULT_FRAME_LEN;
    localparam int COEF_FRAC  = wsci_pkg::DEFAULT_COEF_BITS - 1;
    localparam int STALL_PCT  = 35;
    localparam int QUIET_MAX  = 2000;
    localparam int PHASE_BEATS = 172;

    // Q2.30 fixed-point constants for the coefficient table
    localparam longint          Q30_S  = 64'sd1073741824;
    localparam longint unsigned Q30_U  = 64'd1073741824;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic signed [wsci_pkg::SAMPLE_W-1:0] sample;
        wsci_pkg::slot_tag_t                  tag;
    } beat_t;

    logic clk;
    logic rst_n;

    wsci_adc_if    adc_ch ();
    wsci_result_if res_ch ();
    wsci_cfg_if    cfg_ch ();

    windowed_sample_channel_interleaver_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .adc    (adc_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state
    logic [15:0]                   coef_table [FRAME_LEN];
    logic [wsci_pkg::CHAN_W-1:0]   pred_chan = '0;
    logic [wsci_pkg::SLOT_W-1:0]   pred_slot = '0;
    logic                          pred_bank = 1'b0;
    logic [wsci_pkg::GAIN_W-1:0]   gain_now  = wsci_pkg::GAIN_RESET;

    logic [wsci_pkg::ADC_W-1:0] code_backlog [$];
    beat_t                      sample_forecast [$];

    int  fault_count = 0;
    int  quiet_cycles = 0;
    int  tick = 0;
    wire calm = (tick % 3000) < 500;   // stretch with no stalls on either side

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hamming coefficients: Taylor cosine in Q2.30 over a folded angle, then Q1.15
    initial
    begin : coef_build
        longint unsigned j, m, ang, ang2, term, w;
        longint          c, num;
        bit              neg;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            j = i;
            if (2 * j > FRAME_LEN - 1)
                j = FRAME_LEN - 1 - j;
            neg = (4 * j > FRAME_LEN - 1);
            m = neg ? (FRAME_LEN - 1 - 2 * j) : 2 * j;
            ang  = (m * PI_Q30) / (FRAME_LEN - 1);
            ang2 = (ang * ang) >> 30;
            c    = Q30_S;
            term = Q30_U;
            for (int k = 1; k <= 12; k++)
            begin
                term = ((term * ang2) >> 30) / (64'(2 * k - 1) * 64'(2 * k));
                if (k % 2 == 1)
                    c = c - $signed(term);
                else
                    c = c + $signed(term);
            end
            if (neg)
                c = -c;
            num = 54 * Q30_S - 46 * c;
            if (num < 0)
                num = 0;
            w = (($unsigned(num) << COEF_FRAC) + 50 * Q30_U) / (100 * Q30_U);
            coef_table[i] = w[15:0];
        end
    end

    // Window, gain, clamp, and slot/bank bookkeeping for one ADC code
    function automatic beat_t forecast_beat(input logic [wsci_pkg::ADC_W-1:0] code);
        beat_t           b;
        int              d;
        int              s;
        longint unsigned mag;
        longint unsigned prod;
        d    = int'(code) - 2048;
        mag  = (d < 0) ? 64'(-d) : 64'(d);
        prod = (mag * 64'(coef_table[pred_slot]) * 64'(gain_now)) >> COEF_FRAC;
        if (d < 0)
            s = (prod > 2048) ? -2048 : -int'(prod);
        else
            s = (prod > 2047) ? 2047 : int'(prod);
        b.sample           = s[wsci_pkg::SAMPLE_W-1:0];
        b.tag.channel_slot = pred_chan;
        b.tag.frame_slot   = pred_slot;
        b.tag.bank_sel     = pred_bank;
        b.tag.frame_done   = 1'b0;
        if (pred_chan == wsci_pkg::LAST_CHANNEL)
        begin
            pred_chan = '0;
            if (pred_slot == FRAME_LEN - 1)
            begin
                // frame wrap: swap banks, pulse done for this beat only
                pred_slot        = '0;
                pred_bank        = ~pred_bank;
                b.tag.frame_done = 1'b1;
            end
            else
                pred_slot = pred_slot + 1'b1;
        end
        else
            pred_chan = pred_chan + 1'b1;
        b.tag.next_channel = pred_chan;
        return b;
    endfunction

    // ADC driver: holds valid until accepted, predicts each accepted beat
    always @(posedge clk)
    begin : adc_driver
        logic took;
        if (!rst_n)
        begin
            adc_ch.valid    <= 1'b0;
            adc_ch.adc_code <= '0;
        end
        else
        begin
            took = adc_ch.valid && adc_ch.ready;
            if (took)
            begin
                sample_forecast.push_back(forecast_beat(adc_ch.adc_code));
                void'(code_backlog.pop_front());
            end
            if (!adc_ch.valid || took)
            begin
                if (code_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PCT))
                begin
                    adc_ch.valid    <= 1'b1;
                    adc_ch.adc_code <= code_backlog[0];
                end
                else
                    adc_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge clk)
    begin : result_monitor
        beat_t seen;
        beat_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen.sample           = res_ch.sample_out;
                seen.tag.channel_slot = res_ch.channel_slot;
                seen.tag.frame_slot   = res_ch.frame_slot;
                seen.tag.bank_sel     = res_ch.bank_sel;
                seen.tag.frame_done   = res_ch.frame_done;
                seen.tag.next_channel = res_ch.next_channel;
                if (sample_forecast.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("[%0t] unexpected result: sample %0d chan %0d slot %0d",
                                 $realtime, seen.sample, seen.tag.channel_slot,
                                 seen.tag.frame_slot);
                end
                else
                begin
                    want = sample_forecast.pop_front();
                    if (seen.sample !== want.sample
                        || seen.tag.channel_slot !== want.tag.channel_slot
                        || seen.tag.frame_slot !== want.tag.frame_slot
                        || seen.tag.bank_sel !== want.tag.bank_sel
                        || seen.tag.frame_done !== want.tag.frame_done
                        || seen.tag.next_channel !== want.tag.next_channel)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display({"[%0t] mismatch exp smp %0d ch %0d slot %0d bank %0d ",
                                      "done %0d nxt %0d / got smp %0d ch %0d slot %0d ",
                                      "bank %0d done %0d nxt %0d"},
                                     $realtime, want.sample, want.tag.channel_slot,
                                     want.tag.frame_slot, want.tag.bank_sel,
                                     want.tag.frame_done, want.tag.next_channel,
                                     seen.sample, seen.tag.channel_slot,
                                     seen.tag.frame_slot, seen.tag.bank_sel,
                                     seen.tag.frame_done, seen.tag.next_channel);
                    end
                end
            end
            res_ch.ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    // Watchdog: cycles without any beat on any channel
    always @(posedge clk)
    begin
        tick <= tick + 1;
        if (!rst_n || (adc_ch.valid && adc_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("windowed_sample_channel_interleaver_core_tb: FAIL");
            $finish;
        end
    end

    // Wait until every queued code went in and every result came back
    task automatic drain();
        while (code_backlog.size() != 0 || sample_forecast.size() != 0)
            @(posedge clk);
    endtask

    // Gain write; only called with the block drained
    task automatic write_gain(input logic [wsci_pkg::GAIN_W-1:0] g);
        @(posedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.adc_gain <= g;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        gain_now = g;
        cfg_ch.valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin : stimulus
        logic [wsci_pkg::GAIN_W-1:0] phase_gain [8];
        logic [wsci_pkg::ADC_W-1:0]  code;
        rst_n           = 1'b0;
        adc_ch.valid    = 1'b0;
        adc_ch.adc_code = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.adc_gain = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and bit patterns at reset gain
        code_backlog = '{12'd0, 12'hFFF, 12'd2048, 12'd2047, 12'd2049,
                         12'd1, 12'hFFE, 12'hAAA, 12'h555, 12'h7FF};
        drain();
        // Full gain: full-scale codes clamp in both directions
        write_gain(4'd15);
        code_backlog = '{12'd0, 12'hFFF, 12'd1, 12'hFFE, 12'd300, 12'd3800, 12'd2048};
        drain();
        // Zero gain forces a zero sample
        write_gain(4'd0);
        code_backlog = '{12'd0, 12'hFFF, 12'd2048, 12'd1234};
        drain();
        write_gain(4'd1);
        code_backlog = '{12'd0, 12'hFFF, 12'd2049, 12'd2047};
        drain();

        // Random phases across a spread of gains, each drained before the next write
        phase_gain = '{4'd7, 4'd15, 4'd0, 4'd1, 4'd10, 4'd3, 4'd0, 4'd0};
        phase_gain[6] = 4'($urandom_range(0, 15));
        phase_gain[7] = 4'($urandom_range(0, 15));
        for (int p = 0; p < 8; p++)
        begin
            write_gain(phase_gain[p]);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       code = $urandom_range(0, 1) ? 12'hFFF : 12'd0;
                    1, 2:    code = 12'($urandom_range(2048 - 64, 2048 + 64));
                    default: code = 12'($urandom_range(0, 4095));
                endcase
                code_backlog.push_back(code);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fault_count == 0 && sample_forecast.size() == 0)
            $display("windowed_sample_channel_interleaver_core_tb: PASS");
        else
            $display("windowed_sample_channel_interleaver_core_tb: FAIL");
        $finish;
    end

endmodule
